[design/assert_macros.svh]
// Assertion macros shared by the sorted set union and intersection design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSUI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSUI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ssui_pkg.sv]
// Package: constants, codes and shared types of the sorted set union and intersection core.
`default_nettype none

package ssui_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_INS_A = 2'd0,
        ACT_INS_B = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_UNION = 2'd0,
        KIND_INTER = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_UNION,
        ST_INTER,
        ST_END
    } state_t;

    // Request to one list memory: one write port and one registered read port.
    typedef struct packed {
        logic                          we;
        logic [IDX_W-1:0]              waddr;
        logic signed [VALUE_BITS-1:0]  wdata;
        logic [IDX_W-1:0]              raddr;
    } mem_req_t;

    // One result word handed from the sequencer to the output register.
    typedef struct packed {
        logic                          valid;
        logic signed [VALUE_BITS-1:0]  value;
        kind_t                         kind;
        logic                          ovf;
        logic                          last;
    } emit_t;

endpackage

`default_nettype wire

[design/ssui_list_ram.sv]
// Synchronous list memory with one write port and one registered read port.
`default_nettype none

module ssui_list_ram (
    input  wire logic                                  clk,
    input  wire ssui_pkg::mem_req_t                    req,
    output logic signed [ssui_pkg::VALUE_BITS-1:0]     rd_data
);

    logic signed [ssui_pkg::VALUE_BITS-1:0] mem_reg [ssui_pkg::LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        rd_data <= mem_reg[req.raddr];
    end

endmodule

`default_nettype wire

[design/ssui_out_reg.sv]
// Output register that holds one result word until the consumer takes it.
`default_nettype none

module ssui_out_reg (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ssui_pkg::emit_t                       emit,
    output logic                                       out_ready,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [ssui_pkg::VALUE_BITS-1:0]     value_out,
    output logic [1:0]                                 set_kind,
    output logic                                       overflow,
    output logic                                       last
);

    logic                                   valid_reg;
    logic signed [ssui_pkg::VALUE_BITS-1:0] value_reg;
    ssui_pkg::kind_t                        kind_reg;
    logic                                   ovf_reg;
    logic                                   last_reg;

    // The slot can take a new word when it is empty or its word leaves now.
    assign out_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            value_reg <= emit.value;
            kind_reg  <= emit.kind;
            ovf_reg   <= emit.ovf;
            last_reg  <= emit.last;
        end
    end

    assign out_valid = valid_reg;
    assign value_out = value_reg;
    assign set_kind  = kind_reg;
    assign overflow  = ovf_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[design/ssui_ctrl.sv]
// Sequencer: sorted insertion, merge walks for union and intersection, list counts.
`default_nettype none
`include "assert_macros.svh"

module ssui_ctrl (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [1:0]                            action,
    input  wire logic signed [ssui_pkg::VALUE_BITS-1:0] value,
    input  wire logic signed [ssui_pkg::VALUE_BITS-1:0] rd_a,
    input  wire logic signed [ssui_pkg::VALUE_BITS-1:0] rd_b,
    output ssui_pkg::mem_req_t                         req_a,
    output ssui_pkg::mem_req_t                         req_b,
    output ssui_pkg::emit_t                            emit,
    input  wire logic                                  out_ready
);

    localparam int CNT_W = ssui_pkg::CNT_W;
    localparam int IDX_W = ssui_pkg::IDX_W;

    ssui_pkg::state_t                        state_reg, state_next;
    logic [CNT_W-1:0]                        count_a_reg, count_a_next;
    logic [CNT_W-1:0]                        count_b_reg, count_b_next;
    logic                                    ovf_reg, ovf_next;
    logic                                    sel_reg, sel_next;
    logic signed [ssui_pkg::VALUE_BITS-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]                        i_reg, i_next;
    logic [CNT_W-1:0]                        j_reg, j_next;
    logic                                    have_prev_reg, have_prev_next;
    logic signed [ssui_pkg::VALUE_BITS-1:0]  prev_reg, prev_next;

    logic                                    a_left;
    logic                                    b_left;
    logic                                    take_a;
    logic signed [ssui_pkg::VALUE_BITS-1:0]  pick;
    logic signed [ssui_pkg::VALUE_BITS-1:0]  rd_sel;
    logic [CNT_W-1:0]                        cnt_sel;
    logic [CNT_W-1:0]                        ptr_dec;
    ssui_pkg::mem_req_t                      wr_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssui_pkg::ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        val_reg  <= val_next;
        prev_reg <= prev_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        ovf_next       = ovf_reg;
        sel_next       = sel_reg;
        val_next       = val_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        wr_req         = '0;
        emit           = '0;
        emit.kind      = ssui_pkg::KIND_UNION;

        a_left  = i_reg < count_a_reg;
        b_left  = j_reg < count_b_reg;
        take_a  = !b_left || (a_left && (rd_a <= rd_b));
        pick    = take_a ? rd_a : rd_b;
        rd_sel  = sel_reg ? rd_b : rd_a;
        cnt_sel = (action == ssui_pkg::ACT_INS_B) ? count_b_reg : count_a_reg;

        in_stall = (state_reg != ssui_pkg::ST_IDLE);

        case (state_reg)
            ssui_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ssui_pkg::ACT_INS_A, ssui_pkg::ACT_INS_B:
                        begin
                            if (cnt_sel == CNT_W'(ssui_pkg::LIST_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                sel_next   = (action == ssui_pkg::ACT_INS_B);
                                val_next   = value;
                                i_next     = cnt_sel;
                                state_next = ssui_pkg::ST_INSERT;
                            end
                        end
                        ssui_pkg::ACT_RUN:
                        begin
                            i_next         = '0;
                            j_next         = '0;
                            have_prev_next = 1'b0;
                            state_next     = ssui_pkg::ST_UNION;
                        end
                        default:
                        begin
                            count_a_next = '0;
                            count_b_next = '0;
                        end
                    endcase
                end
            end

            ssui_pkg::ST_INSERT:
            begin
                // Walk down from the top; entries not below the new value move up one.
                wr_req.we    = 1'b1;
                wr_req.waddr = i_reg[IDX_W-1:0];
                if ((i_reg != '0) && (rd_sel >= val_reg))
                begin
                    wr_req.wdata = rd_sel;
                    i_next       = i_reg - CNT_W'(1);
                end
                else
                begin
                    wr_req.wdata = val_reg;
                    if (sel_reg)
                    begin
                        count_b_next = count_b_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_a_next = count_a_reg + CNT_W'(1);
                    end
                    state_next = ssui_pkg::ST_IDLE;
                end
            end

            ssui_pkg::ST_UNION:
            begin
                if (!a_left && !b_left)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    have_prev_next = 1'b0;
                    state_next     = ssui_pkg::ST_INTER;
                end
                else if (out_ready)
                begin
                    if (take_a)
                    begin
                        i_next = i_reg + CNT_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                    if (!have_prev_reg || (pick != prev_reg))
                    begin
                        emit.valid     = 1'b1;
                        emit.value     = pick;
                        emit.kind      = ssui_pkg::KIND_UNION;
                        prev_next      = pick;
                        have_prev_next = 1'b1;
                    end
                end
            end

            ssui_pkg::ST_INTER:
            begin
                if (!(a_left && b_left))
                begin
                    state_next = ssui_pkg::ST_END;
                end
                else if (out_ready)
                begin
                    if (rd_a < rd_b)
                    begin
                        i_next = i_reg + CNT_W'(1);
                    end
                    else if (rd_b < rd_a)
                    begin
                        j_next = j_reg + CNT_W'(1);
                    end
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                        j_next = j_reg + CNT_W'(1);
                        if (!have_prev_reg || (rd_a != prev_reg))
                        begin
                            emit.valid     = 1'b1;
                            emit.value     = rd_a;
                            emit.kind      = ssui_pkg::KIND_INTER;
                            prev_next      = rd_a;
                            have_prev_next = 1'b1;
                        end
                    end
                end
            end

            ssui_pkg::ST_END:
            begin
                if (out_ready)
                begin
                    emit.valid = 1'b1;
                    emit.value = '0;
                    emit.kind  = ssui_pkg::KIND_END;
                    emit.ovf   = ovf_reg;
                    emit.last  = 1'b1;
                    state_next = ssui_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ssui_pkg::ST_IDLE;
            end
        endcase
    end

    // Read addresses follow the next pointers, so the read data always matches
    // the current pointers. During insertion the entry below the pointer is read.
    assign ptr_dec = i_next - CNT_W'(1);

    always_comb
    begin
        req_a = '0;
        req_b = '0;
        if (state_next == ssui_pkg::ST_INSERT)
        begin
            req_a.raddr = ptr_dec[IDX_W-1:0];
            req_b.raddr = ptr_dec[IDX_W-1:0];
        end
        else
        begin
            req_a.raddr = i_next[IDX_W-1:0];
            req_b.raddr = j_next[IDX_W-1:0];
        end
        req_a.we    = wr_req.we && !sel_reg;
        req_a.waddr = wr_req.waddr;
        req_a.wdata = wr_req.wdata;
        req_b.we    = wr_req.we && sel_reg;
        req_b.waddr = wr_req.waddr;
        req_b.wdata = wr_req.wdata;
    end

    `SSUI_ASSERT_NOW(union_ascending, emit.valid && (emit.kind == ssui_pkg::KIND_UNION) && have_prev_reg, emit.value > prev_reg, "union words out of order")
    `SSUI_ASSERT_NOW(inter_ascending, emit.valid && (emit.kind == ssui_pkg::KIND_INTER) && have_prev_reg, emit.value > prev_reg, "intersection words out of order")
    `SSUI_ASSERT_NOW(insert_ptr_bound, state_reg == ssui_pkg::ST_INSERT, i_reg < CNT_W'(ssui_pkg::LIST_DEPTH) && i_reg <= (sel_reg ? count_b_reg : count_a_reg), "insert pointer beyond list")
    `SSUI_ASSERT_NEXT(overflow_sticky, ovf_reg, ovf_reg, "overflow flag cleared")

endmodule

`default_nettype wire

[design/sorted_set_union_intersection_core.sv]
// Top level of the sorted set union and intersection core.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_stall  | action, value
//   output   | out_valid / out_stall| value_out, set_kind, overflow, last
//
// An insert is accepted in the idle state, then writes each stored entry that moves up
// in turn and ends with the final write of the new value; the pace is set by the
// single write port of the list memory. A clear, or an insert into a full list, is
// done in the idle state. A run walks both lists for the union, then walks them again
// for the intersection, then emits the end word, with the walks advancing
// one merge step per cycle while the output register has room; a stalled output holds the walk.
// Reset clears the counts, the overflow flag and the output valid; list contents
// are not cleared, and no entry past a count is ever used.
`default_nettype none

module sorted_set_union_intersection_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [1:0]                            action,
    input  wire logic signed [ssui_pkg::VALUE_BITS-1:0] value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [ssui_pkg::VALUE_BITS-1:0]     value_out,
    output logic [1:0]                                 set_kind,
    output logic                                       overflow,
    output logic                                       last
);

    ssui_pkg::mem_req_t                      req_a;
    ssui_pkg::mem_req_t                      req_b;
    logic signed [ssui_pkg::VALUE_BITS-1:0]  rd_a;
    logic signed [ssui_pkg::VALUE_BITS-1:0]  rd_b;
    ssui_pkg::emit_t                         emit;
    logic                                    out_ready;

    // The sequencer accepts a word only in its idle state. Each list lives in a
    // memory of its own so that the merge walks read both lists every cycle.
    ssui_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .req_a     (req_a),
        .req_b     (req_b),
        .emit      (emit),
        .out_ready (out_ready)
    );

    ssui_list_ram u_list_a (
        .clk     (clk),
        .req     (req_a),
        .rd_data (rd_a)
    );

    ssui_list_ram u_list_b (
        .clk     (clk),
        .req     (req_b),
        .rd_data (rd_b)
    );

    // The output register decouples the walks from the consumer's stall.
    ssui_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_out (value_out),
        .set_kind  (set_kind),
        .overflow  (overflow),
        .last      (last)
    );

endmodule

`default_nettype wire
